// ===== sv/hla_pkg.sv =====
`default_nettype none
package hla_pkg;

    localparam int N_RHO      = 256;
    localparam int N_THETA    = 128;
    localparam int RHO_W      = $clog2(N_RHO);
    localparam int THETA_W    = $clog2(N_THETA);
    localparam int COUNT_W    = 16;
    localparam int COORD_W    = 16;
    localparam int DELTA_W    = COORD_W + 1;
    localparam int TRIG_W     = 18;
    localparam int OFFSET_W   = 17;
    localparam int SCALE_W    = 24;
    localparam int SCALE_HW   = SCALE_W / 2;
    localparam int ACC_W      = 37;
    localparam int PART_W     = ACC_W + SCALE_HW + 1;
    localparam int PROD_W     = ACC_W + SCALE_W + 1;
    localparam int IDX_W      = PROD_W - 36;
    localparam int VOTE_LAT   = 8;
    localparam int VCNT_W     = $clog2(N_THETA + VOTE_LAT + 1);
    localparam int ADDR_W     = 4;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    localparam logic [ADDR_W-1:0] ADDR_ORIGIN_X   = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_ORIGIN_Y   = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_RHO_OFFSET = 4'h8;
    localparam logic [ADDR_W-1:0] ADDR_RHO_SCALE  = 4'hC;

    localparam logic [1:0] CMD_VOTE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic                        valid;
        logic signed [DELTA_W-1:0]   dx;
        logic signed [DELTA_W-1:0]   dy;
    } t_vote;

    typedef struct packed {
        logic                  clr_en;
        logic [RHO_W-1:0]      clr_addr;
        logic                  rd_en;
        logic [RHO_W-1:0]      rd_addr;
        logic [OFFSET_W-1:0]   rho_offset;
        logic [SCALE_W-1:0]    rho_scale;
    } t_ctl;

    // restoring shift-subtract quotient, used only while building the tables
    function automatic longint unsigned div_small(input longint unsigned num, input int den);
        longint unsigned q;
        longint unsigned rem;
        longint unsigned d;
        int              b;
        q   = '0;
        rem = '0;
        d   = longint'(den);
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [TRIG_W-1:0] trig_q16(input int idx, input bit is_sin);
        longint unsigned v;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned t;
        longint          sum;
        int              n;
        int              k;
        bit              neg;
        logic signed [TRIG_W-1:0] r;
        v   = longint'(2 * idx + 1);
        neg = 1'b0;
        if (v > longint'(N_THETA)) begin
            v   = longint'(2 * N_THETA) - v;
            neg = 1'b1;
        end
        a   = (PI_Q30 * v) / (2 * N_THETA);
        a2  = (a * a) >> 30;
        t   = is_sin ? a : ONE_Q30;
        n   = is_sin ? 2 : 1;
        sum = longint'(t);
        for (k = 1; k <= 8; k++) begin
            t = (t * a2) >> 30;
            t = div_small(t, n * (n + 1));
            n = n + 2;
            if ((k % 2) == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = TRIG_W'((sum + 8192) >>> 14);
        if (!is_sin && neg) begin
            r = -r;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/hla_cell.sv =====
`default_nettype none
module hla_cell
    import hla_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_ctl                       i_ctl,
    input  wire t_vote                      i_vote,
    input  wire logic signed [TRIG_W-1:0]   i_cos,
    input  wire logic signed [TRIG_W-1:0]   i_sin,
    output t_vote                           o_vote,
    output logic                            o_clamp,
    output logic [COUNT_W-1:0]              o_rd_data
);

    logic [COUNT_W-1:0] r_mem [N_RHO];

    t_vote                     r_vote;
    logic                      r_v1, r_v2, r_v3, r_v4;
    logic signed [ACC_W-1:0]   r_rho;
    logic signed [PART_W-1:0]  r_plo, r_phi;
    logic [RHO_W-1:0]          r_idx, r_wr_idx;
    logic                      r_clamp;
    logic [COUNT_W-1:0]        r_rd;

    logic signed [ACC_W-1:0]   n_rho;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [IDX_W-1:0]   n_sidx;
    logic [RHO_W-1:0]          n_idx;
    logic                      n_clamp;

    always_comb begin
        n_rho = ACC_W'(r_vote.dx) * ACC_W'(i_cos)
              + ACC_W'(r_vote.dy) * ACC_W'(i_sin)
              + $signed({{(ACC_W - OFFSET_W - 16){1'b0}}, i_ctl.rho_offset, 16'b0});
        n_prod = (PROD_W'(r_phi) <<< SCALE_HW) + PROD_W'(r_plo);
        n_sidx = IDX_W'(n_prod >>> 36);
        n_clamp = 1'b0;
        n_idx   = n_sidx[RHO_W-1:0];
        if (n_sidx < 0) begin
            n_idx   = '0;
            n_clamp = 1'b1;
        end else if (n_sidx > IDX_W'(N_RHO - 1)) begin
            n_idx   = RHO_W'(N_RHO - 1);
            n_clamp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vote.valid <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_clamp <= 1'b0;
        end else begin
            r_vote.valid <= i_vote.valid;
            r_v1    <= r_vote.valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_clamp <= r_v2 && n_clamp;
        end
        r_vote.dx <= i_vote.dx;
        r_vote.dy <= i_vote.dy;
        r_rho     <= n_rho;
        r_plo     <= PART_W'(r_rho) * $signed({1'b0, i_ctl.rho_scale[SCALE_HW-1:0]});
        r_phi     <= PART_W'(r_rho) * $signed({1'b0, i_ctl.rho_scale[SCALE_W-1:SCALE_HW]});
        r_idx     <= n_idx;
        r_wr_idx  <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            r_rd <= r_mem[r_idx];
        end else if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_ctl.rd_addr];
        end
        if (i_ctl.clr_en) begin
            r_mem[i_ctl.clr_addr] <= '0;
        end else if (r_v4 && r_rd != '1) begin
            r_mem[r_wr_idx] <= r_rd + COUNT_W'(1);
        end
    end

    assign o_vote    = r_vote;
    assign o_clamp   = r_clamp;
    assign o_rd_data = r_rd;

endmodule
`default_nettype wire

// ===== sv/hough_line_accumulator.sv =====
`default_nettype none
// Line Hough accumulator of 256 rho by 128 theta cells, 16-bit saturating counts. A vote
// word travels down a chain of 128 cells, one per theta bin, each holding its own 256-entry
// column; a vote result waits for the chain length plus the per-cell rho, scale and
// read-modify-write stages. A read passes a read state and a capture state; a clear
// writes one row of all columns per cycle. After reset the same clearing pass runs
// before the first word is taken; configuration writes are taken at any time.
module hough_line_accumulator
    import hla_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [1:0]             i_command,
    input  wire logic signed [COORD_W-1:0] i_point_x,
    input  wire logic signed [COORD_W-1:0] i_point_y,
    input  wire logic [RHO_W-1:0]       i_rho_bin,
    input  wire logic [THETA_W-1:0]     i_theta_bin,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [COUNT_W-1:0]          o_cell_count,
    output logic                        o_any_clamped
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_VOTE  = 6'b000100,
        S_READ  = 6'b001000,
        S_RDCAP = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                      r_state;
    logic signed [COORD_W-1:0]   r_origin_x, r_origin_y;
    logic [OFFSET_W-1:0]         r_rho_offset;
    logic [SCALE_W-1:0]          r_rho_scale;
    logic [RHO_W-1:0]            r_clr_addr;
    logic                        r_clr_resp;
    logic [VCNT_W-1:0]           r_vcnt;
    logic [RHO_W-1:0]            r_rd_rho;
    logic [THETA_W-1:0]          r_rd_theta;
    t_vote                       r_vote;
    logic                        r_out_valid;
    logic [COUNT_W-1:0]          r_count;
    logic                        r_any;

    t_ctl                        w_ctl;
    t_vote                       w_link [N_THETA+1];
    logic [N_THETA-1:0]          w_clamp;
    logic [COUNT_W-1:0]          w_rd [N_THETA];
    logic                        w_accept;

    assign pready     = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_rho_offset <= '0;
            r_rho_scale  <= SCALE_W'(65536);
        end else if (psel && penable && pwrite) begin
            case (paddr)
                ADDR_ORIGIN_X:   r_origin_x   <= pwdata[COORD_W-1:0];
                ADDR_ORIGIN_Y:   r_origin_y   <= pwdata[COORD_W-1:0];
                ADDR_RHO_OFFSET: r_rho_offset <= pwdata[OFFSET_W-1:0];
                ADDR_RHO_SCALE:  r_rho_scale  <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_ORIGIN_X:   prdata = 32'($unsigned(r_origin_x));
            ADDR_ORIGIN_Y:   prdata = 32'($unsigned(r_origin_y));
            ADDR_RHO_OFFSET: prdata = 32'(r_rho_offset);
            ADDR_RHO_SCALE:  prdata = 32'(r_rho_scale);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        w_ctl.clr_en     = (r_state == S_CLEAR);
        w_ctl.clr_addr   = r_clr_addr;
        w_ctl.rd_en      = (r_state == S_READ);
        w_ctl.rd_addr    = r_rd_rho;
        w_ctl.rho_offset = r_rho_offset;
        w_ctl.rho_scale  = r_rho_scale;
    end

    assign w_link[0] = r_vote;

    for (genvar g = 0; g < N_THETA; g++) begin : g_cell
        localparam logic signed [TRIG_W-1:0] COS_G = trig_q16(g, 1'b0);
        localparam logic signed [TRIG_W-1:0] SIN_G = trig_q16(g, 1'b1);
        hla_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_vote    (w_link[g]),
            .i_cos     (COS_G),
            .i_sin     (SIN_G),
            .o_vote    (w_link[g+1]),
            .o_clamp   (w_clamp[g]),
            .o_rd_data (w_rd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_clr_resp   <= 1'b0;
            r_vote.valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_vcnt       <= '0;
        end else begin
            r_vote.valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + RHO_W'(1);
                    if (r_clr_addr == RHO_W'(N_RHO - 1)) begin
                        if (r_clr_resp) begin
                            r_state     <= S_OUT;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= '0;
                        r_any   <= 1'b0;
                        case (i_command)
                            CMD_VOTE: begin
                                r_vote.valid <= 1'b1;
                                r_vcnt       <= '0;
                                r_state      <= S_VOTE;
                            end
                            CMD_READ: begin
                                r_state <= S_READ;
                            end
                            CMD_CLEAR: begin
                                r_clr_addr <= '0;
                                r_clr_resp <= 1'b1;
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end
                        endcase
                    end
                end
                S_VOTE: begin
                    r_vcnt <= r_vcnt + VCNT_W'(1);
                    if (|w_clamp) begin
                        r_any <= 1'b1;
                    end
                    if (r_vcnt == VCNT_W'(N_THETA + VOTE_LAT)) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_READ: begin
                    r_state <= S_RDCAP;
                end
                S_RDCAP: begin
                    r_count     <= w_rd[r_rd_theta];
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (w_accept) begin
            r_vote.dx  <= DELTA_W'(i_point_x) - DELTA_W'(r_origin_x);
            r_vote.dy  <= DELTA_W'(i_point_y) - DELTA_W'(r_origin_y);
            r_rd_rho   <= i_rho_bin;
            r_rd_theta <= i_theta_bin;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_count  = r_count;
    assign o_any_clamped = r_any;

endmodule
`default_nettype wire

// ===== sv/hla_checker.sv =====
`default_nettype none
module hla_checker
    import hla_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   o_in_stall,
    input  wire logic                   o_out_valid,
    input  wire logic                   i_out_stall,
    input  wire logic [COUNT_W-1:0]     o_cell_count,
    input  wire logic                   o_any_clamped
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after an accepted word");

    a_count_xor_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cell_count != '0 |-> !o_any_clamped)
        else $error("read result carries clamp flag");

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

endmodule

bind hough_line_accumulator hla_checker u_hla_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_cell_count  (o_cell_count),
    .o_any_clamped (o_any_clamped)
);
`default_nettype wire

// ===== tb/hough_line_accumulator_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module hough_line_accumulator_test;
    import hla_pkg::*;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] px;
        logic [15:0] py;
        logic [7:0]  rbin;
        logic [6:0]  tbin;
        bit          typed;
        logic [15:0] cnt;
        logic        clamp;
    } t_row;

    typedef struct {
        logic [15:0] cnt;
        logic        clamp;
    } t_cell_read;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_command = CMD_VOTE;
    logic signed [COORD_W-1:0] i_point_x = '0;
    logic signed [COORD_W-1:0] i_point_y = '0;
    logic [RHO_W-1:0]          i_rho_bin = '0;
    logic [THETA_W-1:0]        i_theta_bin = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [COUNT_W-1:0]        o_cell_count;
    logic                      o_any_clamped;

    localparam logic [1:0] CMD_NONE = 2'd3;

    logic [15:0]  cell_votes [0:N_RHO*N_THETA-1];
    longint       cos_q16 [0:N_THETA-1];
    longint       sin_q16 [0:N_THETA-1];
    int           last_rho [0:N_THETA-1];
    longint       org_x, org_y;
    longint       rho_off, rho_scl;
    t_cell_read   pending_reads [$];
    int           errors = 0;
    int           words_sent = 0;
    bit           hold_done = 1'b0;
    bit           busy_gaps = 1'b1;

    hough_line_accumulator dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic longint taylor_q16(longint unsigned t, longint unsigned a2, int n);
        longint sum;
        sum = longint'(t);
        for (int k = 1; k <= 8; k++) begin
            t = (t * a2) >> 30;
            t = t / longint'(n * (n + 1));
            n = n + 2;
            if (k % 2 == 1) sum = sum - longint'(t);
            else sum = sum + longint'(t);
        end
        if (sum < 0) sum = 0;
        return (sum + 8192) >>> 14;
    endfunction

    function automatic void build_trig_tables();
        longint unsigned v, a, a2;
        bit neg;
        for (int i = 0; i < N_THETA; i++) begin
            v = 2 * i + 1;
            neg = 1'b0;
            if (v > N_THETA) begin
                v = 2 * N_THETA - v;
                neg = 1'b1;
            end
            a = (64'd3373259426 * v) / (2 * N_THETA);
            a2 = (a * a) >> 30;
            sin_q16[i] = taylor_q16(a, a2, 2);
            cos_q16[i] = taylor_q16(64'd1073741824, a2, 1);
            if (neg) cos_q16[i] = -cos_q16[i];
        end
    endfunction

    function automatic t_cell_read accumulate(t_row w);
        t_cell_read res;
        longint dx, dy, rho, prod, idx;
        res.cnt = '0;
        res.clamp = 1'b0;
        case (w.cmd)
            CMD_VOTE: begin
                dx = longint'($signed(w.px)) - org_x;
                dy = longint'($signed(w.py)) - org_y;
                for (int i = 0; i < N_THETA; i++) begin
                    rho = dx * cos_q16[i] + dy * sin_q16[i] + (rho_off <<< 16);
                    prod = rho * rho_scl;
                    idx = prod >>> 36;
                    if (idx < 0) begin
                        idx = 0;
                        res.clamp = 1'b1;
                    end else if (idx > N_RHO - 1) begin
                        idx = N_RHO - 1;
                        res.clamp = 1'b1;
                    end
                    last_rho[i] = int'(idx);
                    if (cell_votes[idx * N_THETA + i] != 16'hFFFF)
                        cell_votes[idx * N_THETA + i]++;
                end
            end
            CMD_READ: res.cnt = cell_votes[int'(w.rbin) * N_THETA + int'(w.tbin)];
            CMD_CLEAR: foreach (cell_votes[k]) cell_votes[k] = '0;
            default: ;
        endcase
        return res;
    endfunction

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_ORIGIN_X: org_x = longint'($signed(data[15:0]));
            ADDR_ORIGIN_Y: org_y = longint'($signed(data[15:0]));
            ADDR_RHO_OFFSET: rho_off = longint'(data[16:0]);
            default: rho_scl = longint'(data[23:0]);
        endcase
    endtask

    task automatic configure(int ox, int oy, int off, int scl);
        write_reg(ADDR_ORIGIN_X, 32'(ox));
        write_reg(ADDR_ORIGIN_Y, 32'(oy));
        write_reg(ADDR_RHO_OFFSET, 32'(off));
        write_reg(ADDR_RHO_SCALE, 32'(scl));
    endtask

    task automatic send_word(t_row w);
        t_cell_read res;
        int gap;
        gap = 0;
        if (busy_gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= w.cmd;
        i_point_x <= w.px;
        i_point_y <= w.py;
        i_rho_bin <= w.rbin;
        i_theta_bin <= w.tbin;
        do @(posedge i_clk); while (o_in_stall);
        res = accumulate(w);
        if (w.typed) begin
            res.cnt = w.cnt;
            res.clamp = w.clamp;
        end
        pending_reads = {pending_reads, res};
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic t_row random_word(bit wide);
        t_row w;
        int sel;
        w.typed = 1'b0;
        w.cnt = '0;
        w.clamp = 1'b0;
        w.px = 16'($urandom);
        w.py = 16'($urandom);
        w.rbin = 8'($urandom);
        w.tbin = 7'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            w.cmd = CMD_VOTE;
            if (!wide) begin
                w.px = 16'(org_x + $urandom_range(0, 4095));
                w.py = 16'(org_y + $urandom_range(0, 4095));
            end
        end else if (sel < 95) begin
            w.cmd = CMD_READ;
            if (sel < 85) w.rbin = 8'(last_rho[w.tbin]);
        end else if (sel < 97) begin
            w.cmd = CMD_CLEAR;
        end else begin
            w.cmd = CMD_NONE;
        end
        return w;
    endfunction

    t_row directed [] = '{
        '{CMD_READ,  16'h0000, 16'h0000, 8'd0,   7'd0,   1'b1, 16'd0, 1'b0},
        '{CMD_READ,  16'h0000, 16'h0000, 8'd255, 7'd127, 1'b1, 16'd0, 1'b0},
        '{CMD_VOTE,  16'h0000, 16'h0000, 8'd0,   7'd0,   1'b1, 16'd0, 1'b0},
        '{CMD_READ,  16'h0000, 16'h0000, 8'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{CMD_READ,  16'h0000, 16'h0000, 8'd0,   7'd127, 1'b0, 16'd0, 1'b0},
        '{CMD_VOTE,  16'h7FFF, 16'h7FFF, 8'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{CMD_VOTE,  16'h8000, 16'h8000, 8'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{CMD_VOTE,  16'h7FFF, 16'h8000, 8'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{CMD_VOTE,  16'h8000, 16'h7FFF, 8'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{CMD_VOTE,  16'h0100, 16'h0040, 8'd0,   7'd0,   1'b0, 16'd0, 1'b0},
        '{CMD_READ,  16'h0000, 16'h0000, 8'd255, 7'd0,   1'b0, 16'd0, 1'b0},
        '{CMD_READ,  16'h0000, 16'h0000, 8'd255, 7'd127, 1'b0, 16'd0, 1'b0},
        '{CMD_NONE,  16'hFFFF, 16'hFFFF, 8'd255, 7'd127, 1'b1, 16'd0, 1'b0},
        '{CMD_CLEAR, 16'hFFFF, 16'hFFFF, 8'd255, 7'd127, 1'b1, 16'd0, 1'b0},
        '{CMD_READ,  16'h0000, 16'h0000, 8'd0,   7'd0,   1'b1, 16'd0, 1'b0},
        '{CMD_READ,  16'h0000, 16'h0000, 8'd255, 7'd127, 1'b1, 16'd0, 1'b0}
    };

    initial begin
        int phase_ox [6] = '{0, 0, -32768, 32767, 1000, -2000};
        int phase_oy [6] = '{0, 0, 32767, -32768, -500, 3000};
        int phase_off [6] = '{0, 5793, 131071, 0, 4000, 70000};
        int phase_scl [6] = '{0, 23170, 16777215, 1, 30000, 9000};
        t_row w;
        org_x = 0;
        org_y = 0;
        rho_off = 0;
        rho_scl = 65536;
        build_trig_tables();
        foreach (cell_votes[k]) cell_votes[k] = '0;
        foreach (last_rho[k]) last_rho[k] = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_word(directed[k]);
        drain();
        for (int p = 0; p < 7; p++) begin
            if (p < 6) configure(phase_ox[p], phase_oy[p], phase_off[p], phase_scl[p]);
            else configure(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                           int'($urandom_range(0, 131071)), int'($urandom_range(0, 65535)));
            for (int n = 0; n < 250; n++) begin
                if (n % 50 == 0) busy_gaps = ($urandom_range(0, 3) != 0);
                w = random_word($urandom_range(0, 4) == 0);
                send_word(w);
            end
            drain();
        end
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        int hold;
        int burst;
        t_cell_read exp_read;
        hold = 0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (pending_reads.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    exp_read = pending_reads.pop_front();
                    if (o_cell_count !== exp_read.cnt) begin
                        $error("cell_count expected %0d actual %0d", exp_read.cnt, o_cell_count);
                        errors++;
                    end
                    if (o_any_clamped !== exp_read.clamp) begin
                        $error("any_clamped expected %0d actual %0d",
                               exp_read.clamp, o_any_clamped);
                        errors++;
                    end
                end
            end
            if (!hold_done && words_sent >= 600) begin
                hold_done = 1'b1;
                hold = 3000;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (busy_gaps && $urandom_range(0, 7) == 0) begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
